// ===== rtl/shash_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the SHA-256 stream hasher: round constants, initial
// hash values, byte source codes and the controller/datapath command bundle.
// No dependencies.
package shash_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned ROUNDS      = 64;

	localparam logic [31:0] SHASH_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [5:0] LEN_START     = 6'd56;
	localparam logic [5:0] LAST_SLOT     = 6'd63;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;

	// Source of the byte shifted into the block window.
	localparam logic [1:0] SEL_MSG  = 2'd0;
	localparam logic [1:0] SEL_MARK = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	typedef struct packed {
		logic       shift_byte;
		logic [1:0] byte_sel;
		logic       inc_count;
		logic       load_vars;
		logic       do_round;
		logic [5:0] round;
		logic       add_chain;
		logic       emit_word;
		logic [2:0] word_idx;
		logic       clear_msg;
	} shash_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} shash_sts_t;

endpackage

// ===== rtl/shash_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the SHA-256 stream hasher: block window, message schedule,
// round unit, chaining words and byte counters. Depends on shash_pkg.
module shash_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shash_pkg::shash_cmd_t cmd,
	input  logic [7:0]           msg_byte,
	output shash_pkg::shash_sts_t sts,
	output logic [31:0]          digest_word
);
	import shash_pkg::*;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
		rotr = (x >> s) | (x << (32 - s));
	endfunction

	// w_q[0] is the oldest word; bytes enter at the low end of w_q[15].
	logic [0:15][31:0] w_q;
	logic [31:0]       h_q [8];
	logic [31:0]       v_q [8];
	logic [5:0]        fill_q;
	logic [63:0]       count_q;

	logic [63:0]  bit_len;
	logic [63:0]  len_shift;
	logic [7:0]   byte_in;
	logic [519:0] byte_window;
	logic [31:0]  s0, s1, sched_next;
	logic [31:0]  big0, big1, choose, major, t1, t2;

	assign bit_len   = {count_q[60:0], 3'b000};
	// Length bytes go out most significant first, at slots 56 to 63.
	assign len_shift = bit_len >> {~fill_q[2:0], 3'b000};

	always_comb begin
		case (cmd.byte_sel)
			SEL_MSG:  byte_in = msg_byte;
			SEL_MARK: byte_in = PAD_MARK_BYTE;
			SEL_LEN:  byte_in = len_shift[7:0];
			default:  byte_in = 8'h00;
		endcase
	end

	assign byte_window = {w_q, byte_in};

	assign s0         = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1         = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign sched_next = w_q[0] + s0 + w_q[9] + s1;

	assign big1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1     = v_q[7] + big1 + choose + SHASH_K[cmd.round] + w_q[0];
	assign big0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2     = big0 + major;

	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			w_q <= byte_window[511:0];
		end else if (cmd.do_round) begin
			w_q <= {w_q[1:15], sched_next};
		end
		if (cmd.load_vars) begin
			v_q <= h_q;
		end else if (cmd.do_round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// While the digest drains, the initial values rotate in behind it, so the
	// chain is ready for the next message after the eighth beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= SHASH_IV;
		end else if (cmd.add_chain) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end else if (cmd.emit_word) begin
			for (int i = 0; i < 7; i++) begin
				h_q[i] <= h_q[i + 1];
			end
			h_q[7] <= SHASH_IV[cmd.word_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.clear_msg) begin
				fill_q <= '0;
			end else if (cmd.shift_byte) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.clear_msg) begin
				count_q <= '0;
			end else if (cmd.inc_count) begin
				count_q <= count_q + 64'd1;
			end
		end
	end

	assign sts.fill    = fill_q;
	assign digest_word = h_q[0];

endmodule

// ===== rtl/shash_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the SHA-256 stream hasher: sequences byte intake, padding,
// compression rounds and digest output. Depends on shash_pkg.
module shash_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_stall,
	input  logic                 byte_valid,
	input  logic                 end_of_message,
	output logic                 digest_valid,
	input  logic                 digest_stall,
	output logic [2:0]           word_index,
	output logic                 last_word,
	input  shash_pkg::shash_sts_t sts,
	output shash_pkg::shash_cmd_t cmd
);
	import shash_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1;
	localparam logic [2:0] ST_FINAL = 3'd2;
	localparam logic [2:0] ST_PAD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [5:0] round_q;
	logic [2:0] widx_q;
	logic       eom_q;
	logic       padding_q;
	logic       first_q;
	logic       spill_q;

	logic block_full;
	logic len_zone;

	assign block_full = (sts.fill == LAST_SLOT);
	assign len_zone   = (sts.fill >= LEN_START);

	always_comb begin
		cmd          = '0;
		cmd.round    = round_q;
		cmd.word_idx = widx_q;
		msg_stall    = 1'b1;
		digest_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				msg_stall = 1'b0;
				if (msg_valid && byte_valid) begin
					cmd.shift_byte = 1'b1;
					cmd.byte_sel   = SEL_MSG;
					cmd.inc_count  = 1'b1;
					cmd.load_vars  = block_full;
				end
			end
			ST_ROUND: cmd.do_round = 1'b1;
			ST_FINAL: cmd.add_chain = 1'b1;
			ST_PAD: begin
				cmd.shift_byte = 1'b1;
				if (first_q) begin
					cmd.byte_sel = SEL_MARK;
				end else if (len_zone && !spill_q) begin
					cmd.byte_sel = SEL_LEN;
				end else begin
					cmd.byte_sel = SEL_ZERO;
				end
				cmd.load_vars = block_full;
			end
			ST_OUT: begin
				digest_valid  = 1'b1;
				cmd.emit_word = !digest_stall;
				cmd.clear_msg = !digest_stall && (widx_q == LAST_WORD_IDX);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			round_q   <= '0;
			widx_q    <= '0;
			eom_q     <= 1'b0;
			padding_q <= 1'b0;
			first_q   <= 1'b0;
			spill_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_valid) begin
						if (byte_valid && block_full) begin
							state_q <= ST_ROUND;
							round_q <= '0;
							eom_q   <= end_of_message;
						end else if (end_of_message) begin
							state_q   <= ST_PAD;
							padding_q <= 1'b1;
							first_q   <= 1'b1;
							spill_q   <= 1'b0;
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (padding_q) begin
						// A marker in the last eight slots pushes the length
						// into one more block.
						if (spill_q) begin
							spill_q <= 1'b0;
							state_q <= ST_PAD;
						end else begin
							widx_q  <= '0;
							state_q <= ST_OUT;
						end
					end else if (eom_q) begin
						eom_q     <= 1'b0;
						padding_q <= 1'b1;
						first_q   <= 1'b1;
						spill_q   <= 1'b0;
						state_q   <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					if (first_q) begin
						first_q <= 1'b0;
						spill_q <= len_zone;
					end
					if (block_full) begin
						round_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_OUT: begin
					if (!digest_stall) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == LAST_WORD_IDX) begin
							padding_q <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign word_index = widx_q;
	assign last_word  = (widx_q == LAST_WORD_IDX);

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// Top level of the SHA-256 stream hasher: joins controller and datapath.
// Depends on shash_pkg, shash_ctrl and shash_dp.

// Each input beat carries at most one message byte and an end-of-message
// flag; at end of message the block pads, finishes the hash and sends the
// digest as eight 32-bit beats, word 0 (most significant) first, then starts
// over for the next message. Input is accepted only while msg_stall is low.
// Every 64th byte starts a compression (64 rounds on a single round unit,
// then a final step that folds the result into the chaining words), during
// which input is stalled. Closing a message shifts in padding bytes up to
// the end of the block, runs one compression (two when the 0x80 marker lands
// in the last eight byte slots) and then sends eight output beats, while
// input stays stalled until the last digest beat is taken.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shash_pkg::*;

	shash_cmd_t cmd;
	shash_sts_t sts;

	shash_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_stall      (msg_stall),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.digest_valid   (digest_valid),
		.digest_stall   (digest_stall),
		.word_index     (word_index),
		.last_word      (last_word),
		.sts            (sts),
		.cmd            (cmd)
	);

	shash_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.msg_byte    (msg_byte),
		.sts         (sts),
		.digest_word (digest_word)
	);

	// No input is taken while the digest drains.
	a_no_input_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> msg_stall)
		else $error("input accepted while digest beats are pending");

	// A digest is only sent after the block window has been emptied.
	a_fill_empty_on_output: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (sts.fill == 6'd0))
		else $error("digest sent with bytes left in the block window");

	// The schedule window is never loaded and advanced in the same cycle.
	a_no_shift_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.do_round && cmd.shift_byte))
		else $error("byte shifted into the window during a round");

	// After the final digest beat the output channel goes quiet.
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && last_word) |=> !digest_valid)
		else $error("digest beats continue after the last word");

endmodule
